@@ design/rfp_pkg.sv @@
package rfp_pkg;

	// Parser phase
	typedef enum logic [2:0] {
		PH_HUNT1,
		PH_HUNT2,
		PH_CMD,
		PH_LEN,
		PH_DATA,
		PH_SUML,
		PH_SUMH
	} phase_t;

	// Result status codes
	localparam logic [2:0] ST_INFO_OK      = 3'd0;
	localparam logic [2:0] ST_SET_OK       = 3'd1;
	localparam logic [2:0] ST_SET_REJECTED = 3'd2;
	localparam logic [2:0] ST_CSUM_ERROR   = 3'd3;
	localparam logic [2:0] ST_ZERO_LENGTH  = 3'd4;
	localparam logic [2:0] ST_UNKNOWN_CMD  = 3'd5;
	localparam logic [2:0] ST_INFO_SHORT   = 3'd6;
	localparam logic [2:0] ST_SET_BAD_LEN  = 3'd7;

	// Register indexes (byte address / 4)
	localparam logic [2:0] REG_HEADER_FIRST  = 3'd0;
	localparam logic [2:0] REG_HEADER_SECOND = 3'd1;
	localparam logic [2:0] REG_INFO_CMD      = 3'd2;
	localparam logic [2:0] REG_SET_POWER_CMD = 3'd3;
	localparam logic [2:0] REG_LIGHT_CMD     = 3'd4;
	localparam logic [2:0] REG_SUCCESS_CODE  = 3'd5;

	localparam int unsigned ADDR_W = 5;

	// Info reply layout
	localparam logic [7:0] INFO_MODE_INDEX = 8'd24;
	localparam logic [7:0] INFO_MIN_LENGTH = 8'd25;

	typedef struct packed {
		logic [7:0] header_first;
		logic [7:0] header_second;
		logic [7:0] info_command;
		logic [7:0] set_power_command;
		logic [7:0] light_command;
		logic [7:0] success_code;
	} cfg_t;

	// Packed so that status sits in the lowest bits
	typedef struct packed {
		logic [7:0] exec_flags;
		logic [7:0] power_mode;
		logic [7:0] command;
		logic [2:0] status;
	} result_t;

	// Parser core handshake toward the top level
	typedef struct packed {
		logic    res_valid;  // accepted word closes a frame
		logic    emit_phase; // next accepted word may close a frame
		result_t res;
	} core_out_t;

endpackage

@@ design/rfp_cfg_regs.sv @@
module rfp_cfg_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rfp_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output rfp_pkg::cfg_t               cfg
);
	import rfp_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] reg_idx;

	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_first      <= 8'h55;
			cfg_q.header_second     <= 8'hAA;
			cfg_q.info_command      <= 8'hD1;
			cfg_q.set_power_command <= 8'hC3;
			cfg_q.light_command     <= 8'hC1;
			cfg_q.success_code      <= 8'h00;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_HEADER_FIRST:  cfg_q.header_first      <= pwdata[7:0];
				REG_HEADER_SECOND: cfg_q.header_second     <= pwdata[7:0];
				REG_INFO_CMD:      cfg_q.info_command      <= pwdata[7:0];
				REG_SET_POWER_CMD: cfg_q.set_power_command <= pwdata[7:0];
				REG_LIGHT_CMD:     cfg_q.light_command     <= pwdata[7:0];
				REG_SUCCESS_CODE:  cfg_q.success_code      <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_HEADER_FIRST:  prdata = {24'd0, cfg_q.header_first};
			REG_HEADER_SECOND: prdata = {24'd0, cfg_q.header_second};
			REG_INFO_CMD:      prdata = {24'd0, cfg_q.info_command};
			REG_SET_POWER_CMD: prdata = {24'd0, cfg_q.set_power_command};
			REG_LIGHT_CMD:     prdata = {24'd0, cfg_q.light_command};
			REG_SUCCESS_CODE:  prdata = {24'd0, cfg_q.success_code};
			default:           prdata = 32'd0;
		endcase
	end

endmodule

@@ design/rfp_parser.sv @@
module rfp_parser (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rfp_pkg::cfg_t         cfg,
	input  logic                  in_accept,
	input  logic [7:0]            in_byte,
	output rfp_pkg::core_out_t    core_out
);
	import rfp_pkg::*;

	phase_t      phase_q, phase_d;
	logic [7:0]  cmd_q, cmd_d;
	logic [7:0]  len_q, len_d;
	logic [7:0]  count_q, count_d;
	logic [15:0] sum_q, sum_d;
	logic [7:0]  first_q, first_d;
	logic [7:0]  mode_q, mode_d;
	logic [7:0]  sum_low_q, sum_low_d;

	logic [15:0] sum_add;
	logic [7:0]  count_inc;
	logic [15:0] got_sum;

	assign sum_add   = sum_q + {8'd0, in_byte};
	assign count_inc = count_q + 8'd1;
	assign got_sum   = {in_byte, sum_low_q};

	// Next state
	always_comb begin
		phase_d   = phase_q;
		cmd_d     = cmd_q;
		len_d     = len_q;
		count_d   = count_q;
		sum_d     = sum_q;
		first_d   = first_q;
		mode_d    = mode_q;
		sum_low_d = sum_low_q;
		unique case (phase_q)
			PH_HUNT1: begin
				if (in_byte == cfg.header_first) begin
					sum_d   = {8'd0, in_byte};
					phase_d = PH_HUNT2;
				end
			end
			PH_HUNT2: begin
				priority if (in_byte == cfg.header_second) begin
					sum_d   = sum_add;
					phase_d = PH_CMD;
				end else if (in_byte == cfg.header_first) begin
					// repeated first header byte restarts the sum
					sum_d = {8'd0, in_byte};
				end else begin
					phase_d = PH_HUNT1;
				end
			end
			PH_CMD: begin
				cmd_d   = in_byte;
				sum_d   = sum_add;
				phase_d = PH_LEN;
			end
			PH_LEN: begin
				len_d   = in_byte;
				sum_d   = sum_add;
				count_d = 8'd0;
				first_d = 8'd0;
				mode_d  = 8'd0;
				phase_d = (in_byte == 8'd0) ? PH_HUNT1 : PH_DATA;
			end
			PH_DATA: begin
				sum_d = sum_add;
				if (count_q == 8'd0) begin
					first_d = in_byte;
				end
				if (count_q == INFO_MODE_INDEX) begin
					mode_d = in_byte;
				end
				count_d = count_inc;
				if (count_inc == len_q) begin
					phase_d = PH_SUML;
				end
			end
			PH_SUML: begin
				sum_low_d = in_byte;
				phase_d   = PH_SUMH;
			end
			PH_SUMH: begin
				phase_d = PH_HUNT1;
			end
			default: begin
				phase_d = PH_HUNT1;
			end
		endcase
	end

	// Result of the word at hand
	always_comb begin
		core_out.emit_phase     = (phase_q == PH_LEN) || (phase_q == PH_SUMH);
		core_out.res_valid      = 1'b0;
		core_out.res.command    = cmd_q;
		core_out.res.power_mode = 8'd0;
		core_out.res.exec_flags = 8'd0;
		core_out.res.status     = ST_CSUM_ERROR;
		if (phase_q == PH_LEN) begin
			core_out.res_valid  = in_accept && (in_byte == 8'd0);
			core_out.res.status = ST_ZERO_LENGTH;
		end else if (phase_q == PH_SUMH) begin
			core_out.res_valid = in_accept;
			priority if (got_sum != sum_q) begin
				core_out.res.status = ST_CSUM_ERROR;
			end else if (cmd_q == cfg.info_command) begin
				if (len_q < INFO_MIN_LENGTH) begin
					core_out.res.status = ST_INFO_SHORT;
				end else begin
					core_out.res.status     = ST_INFO_OK;
					core_out.res.power_mode = mode_q;
				end
			end else if (cmd_q == cfg.set_power_command || cmd_q == cfg.light_command) begin
				priority if (len_q != 8'd1) begin
					core_out.res.status = ST_SET_BAD_LEN;
				end else if (first_q == cfg.success_code) begin
					core_out.res.status     = ST_SET_OK;
					core_out.res.exec_flags = first_q;
				end else begin
					core_out.res.status     = ST_SET_REJECTED;
					core_out.res.exec_flags = first_q;
				end
			end else begin
				core_out.res.status = ST_UNKNOWN_CMD;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT1;
		end else if (in_accept) begin
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			cmd_q     <= cmd_d;
			len_q     <= len_d;
			count_q   <= count_d;
			sum_q     <= sum_d;
			first_q   <= first_d;
			mode_q    <= mode_d;
			sum_low_q <= sum_low_d;
		end
	end

endmodule

@@ design/reply_frame_parser.sv @@
// Channel   Dir  Word                       Notes
// s_axis    in   rx_byte[7:0]               one received byte per word
// m_axis    out  status,command,power,exec  one word per finished frame
// apb       in   six 8-bit registers        byte address 4*index
//
// Each byte is handled in the cycle it is accepted; up to one byte per cycle.
// A frame result lands in the output register at the edge its last byte is
// accepted and is shown from the next cycle on.
// While a result waits, bytes keep flowing; only a byte that could close a
// frame (length byte or checksum high byte) waits for the output to drain.
// arst_n clears the parser to header hunting and loads register defaults.
module reply_frame_parser (
	input  logic                        clk,
	input  logic                        arst_n,
	// APB configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rfp_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	// byte input
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [7:0]                  s_tdata,   // [7:0] rx_byte
	// frame results
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [31:0]                 m_tdata    // [2:0] status, [10:3] command,
	                                               // [18:11] power_mode,
	                                               // [26:19] exec_flags, rest 0
);
	import rfp_pkg::*;

	cfg_t      cfg;
	core_out_t core_out;
	logic      in_accept;
	logic      m_tvalid_q;
	result_t   m_res_q;

	assign pready = 1'b1;

	rfp_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// A word that cannot close a frame never needs the output slot.
	assign s_tready  = !m_tvalid_q || m_tready || !core_out.emit_phase;
	assign in_accept = s_tvalid && s_tready;

	rfp_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_accept (in_accept),
		.in_byte   (s_tdata),
		.core_out  (core_out)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (core_out.res_valid) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (core_out.res_valid) begin
			m_res_q <= core_out.res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {5'd0, m_res_q};

endmodule

@@ test/reply_frame_parser_tb.sv @@
`timescale 1ns / 100ps

// Byte-stream test of the reply deframer.
// Frames are built from the current register settings and queued as bytes.
// The driver sends them in bursts; every accepted byte goes through a local
// deframer that predicts the frame results.
// The monitor checks each result word against the oldest prediction.
module reply_frame_parser_tb;

	localparam int unsigned CLK_HALF     = 4;
	localparam int unsigned LONG_HOLD    = 300;   // receiver hold-off, cycles
	localparam int unsigned QUIET_LIMIT  = 3000;  // cycles with no word moved
	localparam int unsigned DRAIN_CYCLES = 12;    // settle time once nothing is due

	logic        clk     = 1'b0;
	logic        arst_n  = 1'b0;
	logic        psel    = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite  = 1'b0;
	logic [rfp_pkg::ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata  = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = '0;     // [7:0] rx_byte
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;           // [2:0] status, [10:3] command,
	                                // [18:11] power_mode, [26:19] exec_flags

	reply_frame_parser uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	initial begin
		forever #(CLK_HALF) clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Shadow registers, kept in step with every APB write
	// ------------------------------------------------------------------
	rfp_pkg::cfg_t cfg = '{
		header_first:      8'h55,
		header_second:     8'hAA,
		info_command:      8'hD1,
		set_power_command: 8'hC3,
		light_command:     8'hC1,
		success_code:      8'h00
	};

	// ------------------------------------------------------------------
	// Local deframer: state after reset is header hunting, all zero
	// ------------------------------------------------------------------
	rfp_pkg::phase_t  dfr_phase = rfp_pkg::PH_HUNT1;
	logic [7:0]       dfr_cmd   = '0;
	logic [7:0]       dfr_len   = '0;
	logic [7:0]       dfr_count = '0;
	logic [15:0]      dfr_sum   = '0;
	logic [7:0]       dfr_first = '0;
	logic [7:0]       dfr_mode  = '0;
	logic [7:0]       dfr_sum_lo = '0;

	rfp_pkg::result_t frames_due[$];   // predicted result words, oldest first
	logic [7:0]       rx_pending[$];   // bytes waiting for the driver
	int unsigned      bytes_built = 0;
	int unsigned      mismatches  = 0;
	int unsigned      hold_requests = 0;

	function automatic void queue_result(input logic [2:0] st, input logic [7:0] pm,
			input logic [7:0] ex);
		rfp_pkg::result_t r;
		r.status     = st;
		r.command    = dfr_cmd;
		r.power_mode = pm;
		r.exec_flags = ex;
		frames_due.push_back(r);
	endfunction

	function automatic void parse_byte(input logic [7:0] b);
		logic [15:0] got_sum;
		case (dfr_phase)
		rfp_pkg::PH_HUNT1: begin
			// noise is dropped without a word
			if (b == cfg.header_first) begin
				dfr_sum   = {8'h00, b};
				dfr_phase = rfp_pkg::PH_HUNT2;
			end
		end
		rfp_pkg::PH_HUNT2: begin
			if (b == cfg.header_second) begin
				dfr_sum   = dfr_sum + b;
				dfr_phase = rfp_pkg::PH_CMD;
			end else if (b == cfg.header_first) begin
				// repeated first header byte restarts the sum
				dfr_sum = {8'h00, b};
			end else begin
				dfr_phase = rfp_pkg::PH_HUNT1;
			end
		end
		rfp_pkg::PH_CMD: begin
			dfr_cmd   = b;
			dfr_sum   = dfr_sum + b;
			dfr_phase = rfp_pkg::PH_LEN;
		end
		rfp_pkg::PH_LEN: begin
			dfr_len   = b;
			dfr_sum   = dfr_sum + b;
			dfr_count = '0;
			dfr_first = '0;
			dfr_mode  = '0;
			if (b == 8'd0) begin
				// frame ends at the length byte, no checksum follows
				dfr_phase = rfp_pkg::PH_HUNT1;
				queue_result(rfp_pkg::ST_ZERO_LENGTH, 8'd0, 8'd0);
			end else begin
				dfr_phase = rfp_pkg::PH_DATA;
			end
		end
		rfp_pkg::PH_DATA: begin
			dfr_sum = dfr_sum + b;
			if (dfr_count == 8'd0)
				dfr_first = b;
			if (dfr_count == rfp_pkg::INFO_MODE_INDEX)
				dfr_mode = b;
			dfr_count = dfr_count + 8'd1;
			if (dfr_count == dfr_len)
				dfr_phase = rfp_pkg::PH_SUML;
		end
		rfp_pkg::PH_SUML: begin
			dfr_sum_lo = b;
			dfr_phase  = rfp_pkg::PH_SUMH;
		end
		rfp_pkg::PH_SUMH: begin
			got_sum   = {b, dfr_sum_lo};
			dfr_phase = rfp_pkg::PH_HUNT1;
			// checksum first, then command priority: info, set power, light
			if (got_sum != dfr_sum)
				queue_result(rfp_pkg::ST_CSUM_ERROR, 8'd0, 8'd0);
			else if (dfr_cmd == cfg.info_command) begin
				if (dfr_len < rfp_pkg::INFO_MIN_LENGTH)
					queue_result(rfp_pkg::ST_INFO_SHORT, 8'd0, 8'd0);
				else
					queue_result(rfp_pkg::ST_INFO_OK, dfr_mode, 8'd0);
			end else if (dfr_cmd == cfg.set_power_command ||
					dfr_cmd == cfg.light_command) begin
				if (dfr_len != 8'd1)
					queue_result(rfp_pkg::ST_SET_BAD_LEN, 8'd0, 8'd0);
				else if (dfr_first == cfg.success_code)
					queue_result(rfp_pkg::ST_SET_OK, 8'd0, dfr_first);
				else
					queue_result(rfp_pkg::ST_SET_REJECTED, 8'd0, dfr_first);
			end else begin
				queue_result(rfp_pkg::ST_UNKNOWN_CMD, 8'd0, 8'd0);
			end
		end
		default: dfr_phase = rfp_pkg::PH_HUNT1;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Byte driver: bursts of random length, random gaps in between
	// ------------------------------------------------------------------
	int unsigned burst_left = 1;
	int unsigned gap_left   = 0;

	always @(posedge clk) begin : byte_driver
		logic       nxt_valid;
		logic [7:0] nxt_data;
		nxt_valid = s_tvalid;
		nxt_data  = s_tdata;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				parse_byte(s_tdata);
				nxt_valid = 1'b0;
			end
			// an offered byte stays up until taken
			if (!nxt_valid) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (rx_pending.size() != 0) begin
					nxt_data  = rx_pending.pop_front();
					nxt_valid = 1'b1;
					if (burst_left > 0)
						burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 48);
						case ($urandom_range(0, 3))
						0: gap_left = 0;
						1: gap_left = 1;
						2: gap_left = $urandom_range(2, 6);
						default: gap_left = $urandom_range(7, 20);
						endcase
					end
				end
			end
		end
		s_tvalid <= nxt_valid;
		s_tdata  <= nxt_data;
	end

	// ------------------------------------------------------------------
	// Result receiver: stall pattern that changes mode now and then,
	// plus a long hold-off on request to back the block up
	// ------------------------------------------------------------------
	int unsigned rx_cycle    = 0;
	int unsigned stall_mode  = 0;
	int unsigned hold_left   = 0;
	int unsigned hold_served = 0;

	always @(posedge clk) begin : result_receiver
		logic rdy;
		rx_cycle++;
		if (hold_left > 0) begin
			hold_left--;
			rdy = 1'b0;
		end else if (hold_served != hold_requests) begin
			hold_served++;
			hold_left = LONG_HOLD;
			rdy = 1'b0;
		end else begin
			if (rx_cycle % 97 == 0)
				stall_mode = $urandom_range(0, 3);
			case (stall_mode)
			0: rdy = 1'b1;
			1: rdy = 1'($urandom_range(0, 1));
			2: rdy = (rx_cycle % 4 == 0);
			default: rdy = ($urandom_range(0, 9) != 0);
			endcase
		end
		m_tready <= rdy;
	end

	// ------------------------------------------------------------------
	// Result checker
	// ------------------------------------------------------------------
	always @(posedge clk) begin : result_checker
		rfp_pkg::result_t got;
		rfp_pkg::result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = rfp_pkg::result_t'(m_tdata[26:0]);
			if (frames_due.size() == 0) begin
				$display("%0t: unexpected result word %h", $time, m_tdata);
				mismatches++;
			end else begin
				want = frames_due.pop_front();
				if (got.status !== want.status) begin
					$display("%0t: status expected %0d got %0d", $time,
						want.status, got.status);
					mismatches++;
				end
				if (got.command !== want.command) begin
					$display("%0t: command expected %h got %h", $time,
						want.command, got.command);
					mismatches++;
				end
				if (got.power_mode !== want.power_mode) begin
					$display("%0t: power_mode expected %h got %h", $time,
						want.power_mode, got.power_mode);
					mismatches++;
				end
				if (got.exec_flags !== want.exec_flags) begin
					$display("%0t: exec_flags expected %h got %h", $time,
						want.exec_flags, got.exec_flags);
					mismatches++;
				end
				if (m_tdata[31:27] !== 5'd0) begin
					$display("%0t: pad bits expected 00 got %h", $time, m_tdata[31:27]);
					mismatches++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: too long with no word moving on any port
	// ------------------------------------------------------------------
	int unsigned quiet_cycles = 0;

	always @(posedge clk) begin : watchdog
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, quiet_cycles);
			$display("DONE: errors detected");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic apb_write(input logic [2:0] idx, input logic [7:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {24'($urandom), val};   // upper bits are don't-care
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
		rfp_pkg::REG_HEADER_FIRST:  cfg.header_first      = val;
		rfp_pkg::REG_HEADER_SECOND: cfg.header_second     = val;
		rfp_pkg::REG_INFO_CMD:      cfg.info_command      = val;
		rfp_pkg::REG_SET_POWER_CMD: cfg.set_power_command = val;
		rfp_pkg::REG_LIGHT_CMD:     cfg.light_command     = val;
		rfp_pkg::REG_SUCCESS_CODE:  cfg.success_code      = val;
		default: ;
		endcase
	endtask

	task automatic load_config(input logic [7:0] h1, input logic [7:0] h2,
			input logic [7:0] info, input logic [7:0] setp, input logic [7:0] light,
			input logic [7:0] okc);
		apb_write(rfp_pkg::REG_HEADER_FIRST, h1);
		apb_write(rfp_pkg::REG_HEADER_SECOND, h2);
		apb_write(rfp_pkg::REG_INFO_CMD, info);
		apb_write(rfp_pkg::REG_SET_POWER_CMD, setp);
		apb_write(rfp_pkg::REG_LIGHT_CMD, light);
		apb_write(rfp_pkg::REG_SUCCESS_CODE, okc);
	endtask

	// all bytes taken and every predicted word seen, then the DRAIN_CYCLES settle time
	task automatic settle();
		@(negedge clk);
		while (rx_pending.size() != 0 || s_tvalid || frames_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic push_byte(input logic [7:0] b);
		rx_pending.push_back(b);
		bytes_built++;
	endtask

	// header, command, length, data, checksum low then high; a zero length ends after the length byte
	task automatic push_frame(input logic [7:0] cmd, input logic [7:0] len,
			input logic [7:0] lead, input bit bad_sum);
		logic [15:0] sum;
		logic [7:0]  d;
		sum = 16'(cfg.header_first) + 16'(cfg.header_second) + 16'(cmd) + 16'(len);
		push_byte(cfg.header_first);
		push_byte(cfg.header_second);
		push_byte(cmd);
		push_byte(len);
		if (len == 8'd0)
			return;
		for (int i = 0; i < len; i++) begin
			d = (i == 0) ? lead : 8'($urandom);
			sum = sum + 16'(d);
			push_byte(d);
		end
		if (bad_sum)
			sum = sum ^ 16'($urandom_range(1, 16'hFFFF));
		push_byte(sum[7:0]);
		push_byte(sum[15:8]);
	endtask

	function automatic logic [7:0] known_cmd();
		case ($urandom_range(0, 2))
		0: return cfg.info_command;
		1: return cfg.set_power_command;
		default: return cfg.light_command;
		endcase
	endfunction

	task automatic random_frame();
		int unsigned kind;
		logic [7:0]  cmd;
		logic [7:0]  lead;
		kind = $urandom_range(0, 99);
		lead = 8'($urandom);
		cmd  = $urandom_range(0, 1) ? cfg.set_power_command : cfg.light_command;
		if (kind < 30) begin
			// good info reply, now and then the longest one
			push_frame(cfg.info_command,
				($urandom_range(0, 19) == 0) ? 8'd255 : 8'($urandom_range(25, 34)),
				lead, 1'b0);
		end else if (kind < 40) begin
			push_frame(cfg.info_command, 8'($urandom_range(1, 24)), lead, 1'b0);
		end else if (kind < 60) begin
			if ($urandom_range(0, 1))
				lead = cfg.success_code;
			push_frame(cmd, 8'd1, lead, 1'b0);
		end else if (kind < 66) begin
			push_frame(cmd, 8'($urandom_range(2, 5)), lead, 1'b0);
		end else if (kind < 73) begin
			push_frame(8'($urandom), 8'($urandom_range(1, 6)), lead, 1'b0);
		end else if (kind < 78) begin
			push_frame(known_cmd(), 8'd0, lead, 1'b0);
		end else if (kind < 88) begin
			push_frame(known_cmd(), 8'($urandom_range(1, 26)), lead, 1'b1);
		end else begin
			// line noise and broken headers
			case ($urandom_range(0, 2))
			0: repeat ($urandom_range(1, 4)) push_byte(8'($urandom));
			1: begin
				push_byte(cfg.header_first);
				push_byte(8'($urandom));
			end
			default: begin
				push_byte(cfg.header_first);
				push_frame(known_cmd(), 8'd1, lead, 1'b0);
			end
			endcase
		end
	endtask

	task automatic run_phase(input int unsigned budget);
		int unsigned target;
		target = bytes_built + budget;
		while (bytes_built < target)
			random_frame();
		settle();
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, reset register values
		push_byte(8'hFF);                                 // noise while hunting
		push_byte(cfg.header_first);
		push_byte(8'h00);                                 // wrong second header byte
		push_byte(cfg.header_first);                      // first header repeated
		push_frame(cfg.set_power_command, 8'd1, cfg.success_code, 1'b0);
		push_frame(cfg.light_command, 8'd1, 8'hFF, 1'b0); // rejected
		push_frame(cfg.info_command, 8'd0, 8'h00, 1'b0);  // zero length
		settle();

		run_phase(230);

		// random settings, with the receiver backing the block up
		load_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom), 8'($urandom));
		hold_requests++;
		run_phase(260);

		// all registers at zero: equal headers, info wins every command
		load_config(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		run_phase(200);

		// all registers at the top
		load_config(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		run_phase(200);

		// set power and light share a code, info distinct
		load_config(8'h7E, 8'h81, 8'h01, 8'h80, 8'h80, 8'hFF);
		hold_requests++;
		run_phase(250);

		// back to the power-on values
		load_config(8'h55, 8'hAA, 8'hD1, 8'hC3, 8'hC1, 8'h00);
		run_phase(250);

		if (mismatches == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
